// File: rtl/pbc_pkg.sv
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared widths, constants, command/status types and the arcsine threshold
// table builder for the phase-to-bearing block.
// ----------------------------------------------------------------------------
package pbc_pkg;

   localparam int PHASE_W     = 9;
   localparam int SPACING_W   = 14;
   localparam int BEARING_W   = 9;
   localparam int OFS_W       = 18;          // signed path offset
   localparam int DIV_W       = 23;          // phase * wavelength
   localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
   localparam int NUM_ANGLES  = 90;
   localparam int ANGLE_W     = 7;           // holds 0..90
   localparam int ANGLE_IDX_W = $clog2(NUM_ANGLES);
   localparam int SRCH_STEPS  = 7;
   localparam int SRCH_CNT_W  = 3;
   localparam int CSR_IDX_W   = 1;

   // divide by 360 as a shift by three, then a multiply by 2^26 / 45 rounded up;
   // exact for every product of a 9-bit phase and a 14-bit wavelength
   localparam int                 SCALE_SHIFT = 3;
   localparam int                 RECIP_W     = 21;
   localparam int                 RECIP_SHIFT = 26;
   localparam logic [RECIP_W-1:0] RECIP_45    = 21'd1491309;
   localparam int                 SCALE_W     = DIV_W - SCALE_SHIFT + RECIP_W;

   localparam int MAX_RESULTS_DEF     = 10;
   localparam int SINE_TABLE_BITS_DEF = 16;

   localparam logic [SPACING_W-1:0] SPACING_RESET    = 14'd50;
   localparam logic [SPACING_W-1:0] WAVELENGTH_RESET = 14'd200;

   localparam logic [BEARING_W-1:0] FULL_TURN = 9'd360;
   localparam logic [BEARING_W-1:0] HALF_TURN = 9'd180;

   localparam logic [63:0] PI_Q30 = 64'd3373259426;
   localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210, 64'd272};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPACING    = 1'b0,
      CSR_WAVELENGTH = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      EMIT_FIRST  = 2'd0,
      EMIT_SECOND = 2'd1,
      EMIT_NONE   = 2'd2
   } emit_sel_type;

   typedef struct packed {
      logic         cap;
      logic         mul;
      logic         div_start;
      logic         set_p;
      logic         fold_mul;
      logic         fold_sub;
      logic         srch_init;
      logic         srch_mul;
      logic         srch_cmp;
      logic         advance;
      logic         emit;
      logic         emit_last;
      emit_sel_type emit_sel;
   } cmd_type;

   typedef struct packed {
      logic wl_zero;
      logic div_done;
      logic fold_need;
      logic in_range;
      logic next_in;
      logic srch_done;
   } stat_type;

   typedef logic [63:0] thr_arr_type [NUM_ANGLES];

   // Q30 sine by Taylor series, every product and quotient truncated
   function automatic logic [63:0] sin_q30(input logic [63:0] x);
      logic signed [63:0] sum;
      logic [63:0]        term;
      sum  = signed'(x);
      term = x;
      for (int k = 1; k <= 8; k++) begin
         term = (((term * x) >> 30) * x) >> 30;
         term = term / TAYLOR_DIV[k-1];
         if ((k & 1) == 1) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      return (sum < 0) ? 64'd0 : unsigned'(sum);
   endfunction

   // threshold a is sin((a + 0.5) deg), rounded half up to 'bits' fraction bits
   function automatic thr_arr_type build_thr(input int bits);
      thr_arr_type thr;
      logic [63:0] av;
      logic [63:0] ang;
      logic [63:0] s;
      for (int a = 0; a < NUM_ANGLES; a++) begin
         av     = 64'(a);
         ang    = ((64'd2 * av + 64'd1) * PI_Q30 + 64'd180) / 360;
         s      = sin_q30(ang);
         thr[a] = (s + (64'd1 << (29 - bits))) >> (30 - bits);
      end
      return thr;
   endfunction

endpackage

// File: rtl/pbc_div.sv
// ----------------------------------------------------------------------------
// pbc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pbc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pbc_pkg::DIV_W-1:0]     dividend,
   input  logic [pbc_pkg::SPACING_W-1:0] divisor,
   output logic                          done,
   output logic [pbc_pkg::DIV_W-1:0]     quotient
);

   logic [pbc_pkg::SPACING_W-1:0] rem_ff, rem_in;
   logic [pbc_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [pbc_pkg::SPACING_W-1:0] dsr_ff;
   logic [pbc_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [pbc_pkg::SPACING_W:0]   trial;
   logic                          ge;
   logic [pbc_pkg::SPACING_W:0]   diff;

   assign trial = {rem_ff, quo_ff[pbc_pkg::DIV_W-1]};
   assign ge    = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = pbc_pkg::DIV_CNT_W'(pbc_pkg::DIV_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? diff[pbc_pkg::SPACING_W-1:0] : trial[pbc_pkg::SPACING_W-1:0];
         quo_in = {quo_ff[pbc_pkg::DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == pbc_pkg::DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/pbc_datapath.sv
// ----------------------------------------------------------------------------
// pbc_datapath
// Configuration registers, offset scaling and folding, arcsine table search
// and the registered result word.
// ----------------------------------------------------------------------------
module pbc_datapath #(
   parameter int SINE_TABLE_BITS = pbc_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [pbc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pbc_pkg::SPACING_W-1:0]   csr_wdata,
   input  logic [pbc_pkg::PHASE_W-1:0]     req_phase_deg,
   input  pbc_pkg::cmd_type                cmd,
   output pbc_pkg::stat_type               stat,
   output logic                            rsp_valid,
   output logic [pbc_pkg::BEARING_W-1:0]   rsp_bearing_deg,
   output logic                            rsp_last,
   output logic                            rsp_none_found
);

   localparam int TW = SINE_TABLE_BITS + 1;
   localparam int LW = SINE_TABLE_BITS + pbc_pkg::SPACING_W + 1;
   localparam pbc_pkg::thr_arr_type THR = pbc_pkg::build_thr(SINE_TABLE_BITS);

   logic [pbc_pkg::SPACING_W-1:0]   spacing_ff, wavelength_ff;
   logic [pbc_pkg::PHASE_W-1:0]     phase_ff;
   logic [pbc_pkg::DIV_W-1:0]       prod_ff;
   logic signed [pbc_pkg::OFS_W-1:0] p_ff, qw_ff;
   logic [LW-1:0]                   lhs_ff, tprod_ff;
   logic [pbc_pkg::ANGLE_W-1:0]     m_ff;
   logic [pbc_pkg::SRCH_CNT_W-1:0]  sbit_ff;
   logic                            rsp_valid_ff;
   logic [pbc_pkg::BEARING_W-1:0]   bearing_ff, bearing_in;
   logic                            last_ff, none_ff;

   logic signed [pbc_pkg::OFS_W-1:0] d_s, wl_s, lim, fold_num, mag_full;
   logic [pbc_pkg::SPACING_W-1:0]   mag;
   logic [pbc_pkg::SCALE_W-1:0]     scale_full;
   logic                            div_done;
   logic [pbc_pkg::DIV_W-1:0]       div_quot, div_dividend;
   logic [pbc_pkg::OFS_W+pbc_pkg::SPACING_W-1:0] qw_full;
   logic [pbc_pkg::ANGLE_W:0]       cand;
   logic                            cand_ok;
   logic [pbc_pkg::ANGLE_IDX_W-1:0] idx;
   logic [TW-1:0]                   thr_sel;
   logic [LW-1:0]                   tprod_in;
   logic [pbc_pkg::BEARING_W-1:0]   m9, first_b, second_b;

   // configuration, to be written only while idle (a rule for the user that this block leaves unenforced)
   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff    <= pbc_pkg::SPACING_RESET;
         wavelength_ff <= pbc_pkg::WAVELENGTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            pbc_pkg::CSR_SPACING:    spacing_ff    <= csr_wdata;
            pbc_pkg::CSR_WAVELENGTH: wavelength_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign d_s      = signed'(pbc_pkg::OFS_W'(spacing_ff));
   assign wl_s     = signed'(pbc_pkg::OFS_W'(wavelength_ff));
   assign lim      = wl_s - d_s;
   assign fold_num = p_ff - lim + wl_s - pbc_pkg::OFS_W'(1);
   assign mag_full = p_ff[pbc_pkg::OFS_W-1] ? -p_ff : p_ff;
   assign mag      = unsigned'(mag_full[pbc_pkg::SPACING_W-1:0]);

   // phase * wavelength / 360: drop three bits, then multiply by the reciprocal of 45
   assign scale_full = prod_ff[pbc_pkg::DIV_W-1:pbc_pkg::SCALE_SHIFT] * pbc_pkg::RECIP_45;

   assign div_dividend = pbc_pkg::DIV_W'(unsigned'(fold_num));

   pbc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (wavelength_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign qw_full = div_quot[pbc_pkg::OFS_W-1:0] * wavelength_ff;

   // binary search over the threshold table: try m + 2^sbit
   assign cand    = {1'b0, m_ff} + ((pbc_pkg::ANGLE_W+1)'(1) << sbit_ff);
   assign cand_ok = cand <= (pbc_pkg::ANGLE_W+1)'(pbc_pkg::NUM_ANGLES);
   assign idx     = cand_ok ? pbc_pkg::ANGLE_IDX_W'(cand - 1'b1)
                            : pbc_pkg::ANGLE_IDX_W'(pbc_pkg::NUM_ANGLES - 1);
   assign thr_sel  = THR[idx][TW-1:0];
   assign tprod_in = thr_sel * spacing_ff;

   assign m9       = pbc_pkg::BEARING_W'(m_ff);
   assign first_b  = p_ff[pbc_pkg::OFS_W-1] ? pbc_pkg::FULL_TURN - m9 : m9;
   assign second_b = p_ff[pbc_pkg::OFS_W-1] ? pbc_pkg::HALF_TURN + m9
                                            : pbc_pkg::HALF_TURN - m9;

   always_comb begin
      case (cmd.emit_sel)
         pbc_pkg::EMIT_FIRST:  bearing_in = first_b;
         pbc_pkg::EMIT_SECOND: bearing_in = second_b;
         pbc_pkg::EMIT_NONE:   bearing_in = '0;
         default:              bearing_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         phase_ff <= req_phase_deg;
      end
      if (cmd.mul) begin
         prod_ff <= phase_ff * wavelength_ff;
      end
      if (cmd.set_p) begin
         p_ff <= signed'(pbc_pkg::OFS_W'(
                    scale_full[pbc_pkg::SCALE_W-1:pbc_pkg::RECIP_SHIFT]));
      end else if (cmd.fold_sub) begin
         p_ff <= p_ff - qw_ff;
      end else if (cmd.advance) begin
         p_ff <= p_ff + wl_s;
      end
      if (cmd.fold_mul) begin
         qw_ff <= signed'(qw_full[pbc_pkg::OFS_W-1:0]);
      end
      if (cmd.srch_init) begin
         lhs_ff  <= LW'(mag) << SINE_TABLE_BITS;
         m_ff    <= '0;
         sbit_ff <= pbc_pkg::SRCH_CNT_W'(pbc_pkg::SRCH_STEPS - 1);
      end else if (cmd.srch_cmp) begin
         if (cand_ok && (lhs_ff >= tprod_ff)) begin
            m_ff <= cand[pbc_pkg::ANGLE_W-1:0];
         end
         sbit_ff <= sbit_ff - 1'b1;
      end
      if (cmd.srch_mul) begin
         tprod_ff <= tprod_in;
      end
      if (cmd.emit) begin
         bearing_ff <= bearing_in;
         last_ff    <= cmd.emit_last;
         none_ff    <= (cmd.emit_sel == pbc_pkg::EMIT_NONE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   assign stat.wl_zero   = (wavelength_ff == '0);
   assign stat.div_done  = div_done;
   assign stat.fold_need = p_ff > lim;
   assign stat.in_range  = (p_ff > -d_s) && (p_ff < d_s);
   assign stat.next_in   = (p_ff + wl_s) < d_s;
   assign stat.srch_done = (sbit_ff == '0);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bearing_deg = bearing_ff;
   assign rsp_last        = last_ff;
   assign rsp_none_found  = none_ff;

endmodule

// File: rtl/pbc_ctrl.sv
// ----------------------------------------------------------------------------
// pbc_ctrl
// Sequencer: scale, fold if needed, then per offset one table search and up to two results.
// ----------------------------------------------------------------------------
module pbc_ctrl #(
   parameter int MAX_RESULTS = pbc_pkg::MAX_RESULTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  pbc_pkg::stat_type stat,
   output pbc_pkg::cmd_type  cmd,
   output logic              busy
);

   localparam int CW = $clog2(MAX_RESULTS + 1);

   typedef enum logic [11:0] {
      S_IDLE     = 12'b000000000001,
      S_MUL      = 12'b000000000010,
      S_SCALE    = 12'b000000000100,
      S_FOLD_CHK = 12'b000000001000,
      S_DIV_WAIT = 12'b000000010000,
      S_FOLD_SUB = 12'b000000100000,
      S_RANGE    = 12'b000001000000,
      S_SRCH_MUL = 12'b000010000000,
      S_SRCH_CMP = 12'b000100000000,
      S_EMIT1    = 12'b001000000000,
      S_EMIT2    = 12'b010000000000,
      S_NONE     = 12'b100000000000
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            at_limit;

   assign at_limit = (CW'(cnt_ff + 1'b1) == CW'(MAX_RESULTS));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.cap  = 1'b1;
               cnt_in   = '0;
               state_in = stat.wl_zero ? S_NONE : S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.set_p = 1'b1;
            state_in  = S_FOLD_CHK;
         end
         S_FOLD_CHK: begin
            if (stat.fold_need) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV_WAIT;
            end else begin
               state_in = S_RANGE;
            end
         end
         S_DIV_WAIT: begin
            if (stat.div_done) begin
               cmd.fold_mul = 1'b1;
               state_in     = S_FOLD_SUB;
            end
         end
         S_FOLD_SUB: begin
            cmd.fold_sub = 1'b1;
            state_in     = S_RANGE;
         end
         S_RANGE: begin
            if (stat.in_range) begin
               cmd.srch_init = 1'b1;
               state_in      = S_SRCH_MUL;
            end else begin
               state_in = S_NONE;
            end
         end
         S_SRCH_MUL: begin
            cmd.srch_mul = 1'b1;
            state_in     = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            cmd.srch_cmp = 1'b1;
            state_in     = stat.srch_done ? S_EMIT1 : S_SRCH_MUL;
         end
         S_EMIT1: begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = pbc_pkg::EMIT_FIRST;
            cmd.emit_last = at_limit;
            cnt_in        = cnt_ff + 1'b1;
            state_in      = at_limit ? S_IDLE : S_EMIT2;
         end
         S_EMIT2: begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = pbc_pkg::EMIT_SECOND;
            cmd.emit_last = at_limit || !stat.next_in;
            cnt_in        = cnt_ff + 1'b1;
            if (at_limit || !stat.next_in) begin
               state_in = S_IDLE;
            end else begin
               // step to the next wavelength offset
               cmd.advance = 1'b1;
               state_in    = S_RANGE;
            end
         end
         S_NONE: begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = pbc_pkg::EMIT_NONE;
            cmd.emit_last = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// File: rtl/phase_to_bearing_candidates.sv
// ----------------------------------------------------------------------------
// phase_to_bearing_candidates
// Interferometer phase difference to candidate arrival bearings.
// ----------------------------------------------------------------------------
// One phase word is taken when start is high and busy is low; busy then stays
// high until the final result strobe of that word has been shown. Results
// come on rsp_valid for one cycle each and cannot be stalled, so the receiver
// must take every strobe. Scaling by 360 is a multiply followed by a shift
// and a reciprocal multiply, done before the first range check; an offset that
// needs folding adds a 23-step bit-serial divide by the wavelength and the
// fold multiply and subtract. Each candidate offset then takes one range
// check, a seven-step binary search of the sine threshold table with a
// multiply and a compare per step, and up to two results, the two bearings of
// an offset coming in back-to-back cycles. Up to MAX_RESULTS bearings come per
// word; rsp_last marks the final one, and a word with no candidate gives one
// result with rsp_none_found set and bearing zero.
// ----------------------------------------------------------------------------
module phase_to_bearing_candidates #(
   parameter int MAX_RESULTS     = pbc_pkg::MAX_RESULTS_DEF,
   parameter int SINE_TABLE_BITS = pbc_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [pbc_pkg::PHASE_W-1:0]   req_phase_deg,
   output logic                          rsp_valid,
   output logic [pbc_pkg::BEARING_W-1:0] rsp_bearing_deg,
   output logic                          rsp_last,
   output logic                          rsp_none_found,
   input  logic                          csr_we,
   input  logic [pbc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pbc_pkg::SPACING_W-1:0] csr_wdata
);

   pbc_pkg::cmd_type  cmd;
   pbc_pkg::stat_type stat;
   logic              ctrl_busy;
   logic              accept;

   // hold busy through the final registered strobe
   assign busy   = ctrl_busy | rsp_valid;
   assign accept = start & ~busy;

   pbc_ctrl #(
      .MAX_RESULTS (MAX_RESULTS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (ctrl_busy)
   );

   pbc_datapath #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_phase_deg   (req_phase_deg),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_bearing_deg (rsp_bearing_deg),
      .rsp_last        (rsp_last),
      .rsp_none_found  (rsp_none_found)
   );

endmodule

// File: rtl/pbc_checker.sv
// ----------------------------------------------------------------------------
// pbc_checker
// Port-level checks of the phase-to-bearing block, bound to the top level.
// ----------------------------------------------------------------------------
module pbc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [pbc_pkg::BEARING_W-1:0] rsp_bearing_deg,
   input logic                          rsp_last,
   input logic                          rsp_none_found
);

   // an accepted word keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   a_none_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_none_found |-> rsp_last && (rsp_bearing_deg == '0))
      else $error("empty result not final or bearing nonzero");

   a_bearing_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bearing_deg <= pbc_pkg::FULL_TURN)
      else $error("bearing above full turn");

   // no result follows directly on the final result of a word
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result right after final result");

endmodule

bind phase_to_bearing_candidates pbc_checker u_pbc_checker (.*);

// File: verif/phase_to_bearing_candidates_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phase_to_bearing_candidates_tb
// Drives phase words through the start/busy port, rewrites the antenna
// spacing and wavelength registers between runs, and checks each bearing
// word against a local arcsine threshold model of the block.
// ----------------------------------------------------------------------------
module phase_to_bearing_candidates_tb;

   localparam int MAX_RESULTS     = 10;
   localparam int SINE_TABLE_BITS = 16;
   localparam int NUM_THR         = 90;
   localparam longint unsigned ANGLE_PI_Q30 = 64'd3373259426;
   localparam int IDLE_LIMIT      = 2000;
   localparam int DRAIN_CYCLES    = 200;
   localparam int WORDS_PER_RUN   = 34;
   localparam int RANDOM_RUNS     = 12;

   typedef struct {
      logic [pbc_pkg::BEARING_W-1:0] bearing;
      logic                          last;
      logic                          none_found;
   } bearing_word_type;

   typedef logic [pbc_pkg::PHASE_W-1:0] phase_list_type[$];

   logic                            clock         = 1'b0;
   logic                            reset         = 1'b1;
   logic                            start         = 1'b0;
   logic [pbc_pkg::PHASE_W-1:0]     req_phase_deg = '0;
   logic                            csr_we        = 1'b0;
   logic [pbc_pkg::CSR_IDX_W-1:0]   csr_index     = '0;
   logic [pbc_pkg::SPACING_W-1:0]   csr_wdata     = '0;
   logic                            busy;
   logic                            rsp_valid;
   logic [pbc_pkg::BEARING_W-1:0]   rsp_bearing_deg;
   logic                            rsp_last;
   logic                            rsp_none_found;

   bearing_word_type                expected_bearings[$];
   longint unsigned                 sine_thr[NUM_THR];
   logic [pbc_pkg::SPACING_W-1:0]   spacing_reg    = pbc_pkg::SPACING_RESET;
   logic [pbc_pkg::SPACING_W-1:0]   wavelength_reg = pbc_pkg::WAVELENGTH_RESET;
   int                              mismatches     = 0;
   int                              idle_cycles    = 0;
   bit                              burst          = 1'b0;

   phase_to_bearing_candidates #(
      .MAX_RESULTS     (MAX_RESULTS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_phase_deg   (req_phase_deg),
      .rsp_valid       (rsp_valid),
      .rsp_bearing_deg (rsp_bearing_deg),
      .rsp_last        (rsp_last),
      .rsp_none_found  (rsp_none_found),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Q30 sine by truncated Taylor series
   function automatic longint unsigned taylor_sine(input longint unsigned x);
      longint          acc;
      longint unsigned t;
      acc = x;
      t   = x;
      for (int k = 1; k <= 8; k++) begin
         t = (((t * x) >> 30) * x) >> 30;
         t = t / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            acc = acc - longint'(t);
         end else begin
            acc = acc + longint'(t);
         end
      end
      return (acc < 0) ? 64'd0 : longint'(acc);
   endfunction

   // threshold a sits at sin((a + 0.5) deg), rounded half up
   function automatic void build_sine_thr();
      longint unsigned ang;
      for (int a = 0; a < NUM_THR; a++) begin
         ang = (longint'(2 * a + 1) * ANGLE_PI_Q30 + 64'd180) / 64'd360;
         sine_thr[a] = (taylor_sine(ang) + (64'd1 << (29 - SINE_TABLE_BITS)))
                       >> (30 - SINE_TABLE_BITS);
      end
   endfunction

   function automatic int asin_degrees(input longint ofs, input longint d);
      longint unsigned lhs;
      longint unsigned du;
      int              m;
      lhs = (ofs < 0) ? -ofs : ofs;
      lhs = lhs << SINE_TABLE_BITS;
      du  = d;
      m   = 0;
      for (int a = 0; a < NUM_THR; a++) begin
         if (lhs >= sine_thr[a] * du) m++;
      end
      return m;
   endfunction

   function automatic void predict_bearings(input logic [pbc_pkg::PHASE_W-1:0] phase);
      longint           d;
      longint           wl;
      longint           ph;
      longint           p;
      longint           lim;
      int               m;
      int               vals[$];
      bearing_word_type w;
      d  = spacing_reg;
      wl = wavelength_reg;
      ph = phase;
      if (wl != 0) begin
         p   = ph * wl / 360;
         lim = wl - d;
         // fold down by whole wavelengths
         if (p > lim) p = p - ((p - lim + wl - 1) / wl) * wl;
         while (vals.size() < MAX_RESULTS) begin
            if (p <= -d || p >= d) break;
            m = asin_degrees(p, d);
            if (p >= 0) begin
               vals.push_back(m);
               if (vals.size() < MAX_RESULTS) begin
                  vals.push_back(int'(pbc_pkg::HALF_TURN) - m);
               end
            end else begin
               vals.push_back(int'(pbc_pkg::FULL_TURN) - m);
               if (vals.size() < MAX_RESULTS) begin
                  vals.push_back(int'(pbc_pkg::HALF_TURN) + m);
               end
            end
            if (p + wl < d) begin
               p = p + wl;
            end else begin
               break;
            end
         end
      end
      if (vals.size() == 0) begin
         w.bearing    = '0;
         w.last       = 1'b1;
         w.none_found = 1'b1;
         expected_bearings.push_back(w);
      end else begin
         foreach (vals[i]) begin
            w.bearing    = pbc_pkg::BEARING_W'(vals[i]);
            w.last       = (i == vals.size() - 1);
            w.none_found = 1'b0;
            expected_bearings.push_back(w);
         end
      end
   endfunction

   function automatic int pick_gap();
      int r;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 80) return $urandom_range(1, 8);
      if (r < 95) return $urandom_range(9, 60);
      return $urandom_range(61, 200);
   endfunction

   function automatic logic [pbc_pkg::PHASE_W-1:0] pick_phase();
      if ($urandom_range(0, 9) == 0) return pbc_pkg::PHASE_W'($urandom_range(360, 511));
      return pbc_pkg::PHASE_W'($urandom_range(0, 359));
   endfunction

   task automatic send_words(input phase_list_type words);
      int gap;
      gap = 1 + pick_gap();
      foreach (words[i]) begin
         if (gap > 0) repeat (gap) @(posedge clock);
         start         <= 1'b1;
         req_phase_deg <= words[i];
         do @(posedge clock); while (busy);
         predict_bearings(words[i]);
         gap = pick_gap();
         // hold start only when the next word follows at once
         if (i == words.size() - 1 || gap > 0) start <= 1'b0;
      end
   endtask

   task automatic wait_drained();
      while (expected_bearings.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input pbc_pkg::csr_index_type idx,
                            input logic [pbc_pkg::SPACING_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == pbc_pkg::CSR_SPACING) begin
         spacing_reg = value;
      end else begin
         wavelength_reg = value;
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_geometry(input logic [pbc_pkg::SPACING_W-1:0] spacing,
                               input logic [pbc_pkg::SPACING_W-1:0] wl);
      if ($urandom_range(0, 1) == 0) begin
         write_csr(pbc_pkg::CSR_SPACING, spacing);
         write_csr(pbc_pkg::CSR_WAVELENGTH, wl);
      end else begin
         write_csr(pbc_pkg::CSR_WAVELENGTH, wl);
         write_csr(pbc_pkg::CSR_SPACING, spacing);
      end
   endtask

   // defaults after reset: zero offset, boundary offset, folded negative offset
   task automatic test_reset_geometry();
      send_words('{0, 1, 45, 89, 90, 135, 180, 270, 359, 360, 511});
      wait_drained();
   endtask

   task automatic test_edge_geometry();
      set_geometry(14'd0, 14'd200);       // zero spacing: nothing inside
      send_words('{0, 200});
      wait_drained();
      set_geometry(14'd50, 14'd0);        // zero wavelength: no fold
      send_words('{100});
      wait_drained();
      set_geometry(14'd16383, 14'd1);     // many offsets, result limit
      send_words('{0, 511});
      wait_drained();
      set_geometry(14'd16383, 14'd16383);
      send_words('{0, 180, 359});
      wait_drained();
      set_geometry(14'd1, 14'd16383);
      send_words('{0, 1, 511});
      wait_drained();
      set_geometry(14'd16383, 14'd3);     // deep negative fold
      send_words('{100, 359});
      wait_drained();
   endtask

   task automatic test_random_geometry();
      phase_list_type words;
      int             wl;
      int             d;
      for (int run = 0; run < RANDOM_RUNS; run++) begin
         case (run)
            0: begin
               d  = 16383;
               wl = 16383;
            end
            1: begin
               d  = 1;
               wl = 1;
            end
            2: begin
               d  = 16383;
               wl = $urandom_range(1, 64);
            end
            default: begin
               case ($urandom_range(0, 9))
                  0: begin
                     d  = $urandom_range(0, 16383);
                     wl = $urandom_range(0, 16383);
                  end
                  8, 9: begin
                     d  = $urandom_range(1, 16383);
                     wl = $urandom_range(1, d);
                  end
                  default: begin
                     wl = $urandom_range(1, 2000);
                     d  = $urandom_range(1, (3 * wl > 16383) ? 16383 : 3 * wl);
                  end
               endcase
            end
         endcase
         set_geometry(pbc_pkg::SPACING_W'(d), pbc_pkg::SPACING_W'(wl));
         burst = (run % 4 == 3);
         words.delete();
         repeat (WORDS_PER_RUN) words.push_back(pick_phase());
         send_words(words);
         wait_drained();
      end
      burst = 1'b0;
   endtask

   always @(posedge clock) begin : check_bearings
      bearing_word_type want;
      if (!reset && rsp_valid) begin
         if (expected_bearings.size() == 0) begin
            $error("unexpected result word: bearing_deg %0d last %0b none_found %0b",
                   rsp_bearing_deg, rsp_last, rsp_none_found);
            mismatches++;
         end else begin
            want = expected_bearings.pop_front();
            if (rsp_bearing_deg !== want.bearing) begin
               $error("bearing_deg: expected %0d, got %0d", want.bearing, rsp_bearing_deg);
               mismatches++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               mismatches++;
            end
            if (rsp_none_found !== want.none_found) begin
               $error("none_found: expected %0b, got %0b", want.none_found, rsp_none_found);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      build_sine_thr();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_geometry();
      test_edge_geometry();
      test_random_geometry();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_bearings.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/pbc_pkg.sv
rtl/pbc_div.sv
rtl/pbc_datapath.sv
rtl/pbc_ctrl.sv
rtl/phase_to_bearing_candidates.sv
rtl/pbc_checker.sv
verif/phase_to_bearing_candidates_tb.sv
